/* rtl/ils_pkg.sv */
// Shared types and constants for the indexed list store.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package ils_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMP_W   = (CNT_W > 5) ? CNT_W : 5;
    localparam int VAL_W   = 32;
    localparam int ACT_W   = 4;
    localparam int POS_W   = 5;
    localparam int STS_W   = 2;
    localparam int ECNT_W  = 5;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD_FIRST = 4'd0,
        ACT_ADD_LAST  = 4'd1,
        ACT_ADD_AT    = 4'd2,
        ACT_REM_FIRST = 4'd3,
        ACT_REM_LAST  = 4'd4,
        ACT_REM_AT    = 4'd5,
        ACT_GET_FIRST = 4'd6,
        ACT_GET_LAST  = 4'd7,
        ACT_GET_AT    = 4'd8
    } action_t;

    typedef enum logic [STS_W-1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_RANGE = 2'd2,
        STS_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } dp_cmd_t;

    localparam logic [VAL_W-1:0] ERR_VALUE = '1;

endpackage
`default_nettype wire

/* rtl/ils_ctrl.sv */
// Sequencing controller for the indexed list store.
// Depends on ils_pkg for the state type and the datapath command struct.
`default_nettype none
module ils_ctrl
    import ils_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    output logic         done,
    output dp_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b0;
        done       = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                busy       = 1'b1;
                cmd.exec   = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                done = 1'b1;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/ils_datapath.sv */
// Element cell chain, count and result registers of the indexed list store.
// Depends on ils_pkg for widths, action and status codes and the command struct.
`default_nettype none
module ils_datapath
    import ils_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire dp_cmd_t                 cmd,
    input  wire logic [ACT_W-1:0]        action,
    input  wire logic [POS_W-1:0]        position,
    input  wire logic signed [VAL_W-1:0] item_value,
    output logic signed [VAL_W-1:0]      result_value,
    output logic [STS_W-1:0]             status,
    output logic [ECNT_W-1:0]            element_count
);

    action_t          act_reg;
    logic [POS_W-1:0] pos_reg;
    logic [VAL_W-1:0] val_reg;

    logic [VAL_W-1:0] cell_reg  [DEPTH];
    logic [VAL_W-1:0] cell_next [DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [VAL_W-1:0] result_value_reg;
    logic [VAL_W-1:0] result_value_next;
    status_t          status_reg;
    status_t          status_next;

    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] pos_ext;
    logic [CNT_W-1:0] last_idx;
    logic [IDX_W-1:0] slot;
    logic [VAL_W-1:0] rd_data;
    logic             empty;
    logic             full;
    logic             do_ins;
    logic             do_rem;
    logic             is_read;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= action_t'(action);
            pos_reg <= position;
            val_reg <= item_value;
        end
    end

    assign cnt_ext  = CMP_W'(count_reg);
    assign pos_ext  = CMP_W'(pos_reg);
    assign last_idx = count_reg - CNT_W'(1);
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        slot        = '0;
        do_ins      = 1'b0;
        do_rem      = 1'b0;
        is_read     = 1'b0;
        status_next = STS_OK;
        case (act_reg) inside
            ACT_ADD_FIRST, ACT_ADD_LAST:
            begin
                slot = (act_reg == ACT_ADD_FIRST) ? '0 : IDX_W'(count_reg);
                if (full)
                    status_next = STS_FULL;
                else
                    do_ins = 1'b1;
            end
            ACT_ADD_AT:
            begin
                slot = IDX_W'(pos_reg);
                if (empty)
                    status_next = STS_EMPTY;
                else if (pos_ext > cnt_ext)
                    status_next = STS_RANGE;
                else if (full)
                    status_next = STS_FULL;
                else
                    do_ins = 1'b1;
            end
            ACT_REM_FIRST, ACT_REM_LAST, ACT_GET_FIRST, ACT_GET_LAST:
            begin
                is_read = 1'b1;
                if (act_reg == ACT_REM_FIRST || act_reg == ACT_GET_FIRST)
                    slot = '0;
                else
                    slot = IDX_W'(last_idx);
                if (empty)
                    status_next = STS_EMPTY;
                else
                    do_rem = (act_reg == ACT_REM_FIRST || act_reg == ACT_REM_LAST);
            end
            ACT_REM_AT, ACT_GET_AT:
            begin
                is_read = 1'b1;
                slot    = IDX_W'(pos_reg);
                if (empty)
                    status_next = STS_EMPTY;
                else if (pos_ext >= cnt_ext)
                    status_next = STS_RANGE;
                else
                    do_rem = (act_reg == ACT_REM_AT);
            end
            default:
            begin
                status_next = STS_OK;
            end
        endcase
    end

    always_comb
    begin
        rd_data = cell_reg[slot];
    end

    always_comb
    begin
        if (status_next != STS_OK)
            result_value_next = ERR_VALUE;
        else if (is_read)
            result_value_next = rd_data;
        else
            result_value_next = '0;
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (do_ins)
            begin
                if (IDX_W'(i) == slot)
                    cell_next[i] = val_reg;
                else if (i > 0 && IDX_W'(i) > slot)
                    cell_next[i] = cell_reg[(i > 0) ? i - 1 : 0];
            end
            else if (do_rem)
            begin
                if (i < DEPTH - 1 && IDX_W'(i) >= slot)
                    cell_next[i] = cell_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
            count_next = count_reg + CNT_W'(1);
        else if (do_rem)
            count_next = last_idx;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                cell_reg[i] <= cell_next[i];
            end
            result_value_reg <= result_value_next;
            status_reg       <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    assign result_value  = result_value_reg;
    assign status        = status_reg;
    assign element_count = ECNT_W'(count_reg);

endmodule
`default_nettype wire

/* rtl/indexed_list_store_top.sv */
// Indexed list store: request accepted on start while busy is low, executed on the
// cell chain in the EXEC state, result shown with done for one cycle after that.
// The result and status registers load as EXEC ends, so they change as done rises.
// No new request is taken while the cell chain executes and busy is high.
// Reset clears the element count and the controller; stored values need no reset.
// Results cannot be stalled; a new request may be taken while done is high.
`default_nettype none
module indexed_list_store_top
    import ils_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [ACT_W-1:0]        action,
    input  wire logic [POS_W-1:0]        position,
    input  wire logic signed [VAL_W-1:0] item_value,
    output logic                         done,
    output logic signed [VAL_W-1:0]      result_value,
    output logic [STS_W-1:0]             status,
    output logic [ECNT_W-1:0]            element_count
);

    dp_cmd_t cmd;

    ils_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    ils_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .action        (action),
        .position      (position),
        .item_value    (item_value),
        .result_value  (result_value),
        .status        (status),
        .element_count (element_count)
    );

endmodule
`default_nettype wire
